// ===== src/message_queue_with_waiter_masks_assert.svh =====
// Assertion macros for the message queue with waiter masks.
`ifndef MESSAGE_QUEUE_WITH_WAITER_MASKS_ASSERT_SVH
`define MESSAGE_QUEUE_WITH_WAITER_MASKS_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MQWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define MQWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MQWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MQWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/mqwm_pkg.sv =====
// Shared constants, command codes and link types of the message queue.
`default_nettype none

package mqwm_pkg;

    localparam int DEPTH     = 16;
    localparam int TASKS     = 3;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int FILL_W    = 5;
    localparam int MSG_W     = 32;
    localparam int TASK_W    = 2;
    localparam int CAP_RESET = 16;
    localparam int EFF_CAP_RESET = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    typedef enum logic [1:0] {
        CMD_SEND      = 2'd0,
        CMD_READ      = 2'd1,
        CMD_CANCEL_WR = 2'd2,
        CMD_CANCEL_RD = 2'd3
    } cmd_t;

    // Broadcast control to every slot cell
    typedef struct packed {
        logic             wr_adv;
        logic             rd_adv;
        logic [MSG_W-1:0] message;
    } slot_ctl_t;

    // Passed from one slot cell to the next
    typedef struct packed {
        logic             wr_tok;
        logic             rd_tok;
        logic             wr_wrap;
        logic             rd_wrap;
        logic [MSG_W-1:0] rdata;
    } slot_link_t;

    // Broadcast command to every task cell
    typedef struct packed {
        logic              accept;
        cmd_t              cmd;
        logic [TASK_W-1:0] task_id;
        logic              wait_on_fail;
        logic              release_wait;
    } task_op_t;

    // Passed from a lower-numbered task cell to the next
    typedef struct packed {
        logic              found;
        logic [TASK_W-1:0] who;
        logic              timed_out;
    } task_link_t;

endpackage

`default_nettype wire

// ===== src/mqwm_slot_cell.sv =====
// One message slot of the ring, with its write and read pointer tokens.
`default_nettype none

module mqwm_slot_cell
    import mqwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head,
    input  wire logic [PTR_W-1:0] cell_index,
    input  wire logic [CNT_W-1:0] eff_cap,
    input  wire slot_ctl_t        ctl,
    input  wire slot_link_t       link_in,
    output slot_link_t            link_out
);

    logic             wr_tok_reg;
    logic             rd_tok_reg;
    logic [MSG_W-1:0] slot_reg;
    logic [CNT_W-1:0] next_index;
    logic             wrap;

    // Decide whether a token here steps back to slot zero
    assign next_index = CNT_W'(cell_index) + CNT_W'(1);
    assign wrap       = (next_index >= eff_cap);

    // Move the pointer tokens along the ring on each advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_tok_reg <= head;
            rd_tok_reg <= head;
        end
        else
        begin
            if (ctl.wr_adv)
            begin
                wr_tok_reg <= link_in.wr_tok;
            end
            if (ctl.rd_adv)
            begin
                rd_tok_reg <= link_in.rd_tok;
            end
        end
    end

    // Store the message when the write token sits here
    always_ff @(posedge clk)
    begin
        if (ctl.wr_adv && wr_tok_reg)
        begin
            slot_reg <= ctl.message;
        end
    end

    // Hand tokens, wrap flags and the read word to the neighbor
    always_comb
    begin
        link_out.wr_tok  = wr_tok_reg && !wrap;
        link_out.rd_tok  = rd_tok_reg && !wrap;
        link_out.wr_wrap = link_in.wr_wrap | (wr_tok_reg && wrap);
        link_out.rd_wrap = link_in.rd_wrap | (rd_tok_reg && wrap);
        link_out.rdata   = link_in.rdata | (rd_tok_reg ? slot_reg : '0);
    end

endmodule

`default_nettype wire

// ===== src/mqwm_task_cell.sv =====
// Wait bits of one task, with the lowest-task release chain.
`default_nettype none

module mqwm_task_cell
    import mqwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [TASK_W-1:0] my_id,
    input  wire task_op_t          op,
    input  wire task_link_t        link_in,
    output task_link_t             link_out
);

    logic rd_wait_reg;
    logic rd_wait_next;
    logic wr_wait_reg;
    logic wr_wait_next;
    logic mine;
    logic cand;
    logic claim;
    logic failed;

    assign mine   = (op.task_id == my_id);
    assign cand   = (op.cmd == CMD_SEND) ? rd_wait_reg : wr_wait_reg;
    assign claim  = op.accept && op.release_wait && cand && !link_in.found;
    assign failed = op.accept && !op.release_wait && op.wait_on_fail && mine;

    // Pass the lowest waiting task and the cancel hit along the chain
    always_comb
    begin
        link_out.found = link_in.found | cand;
        link_out.who   = (link_in.found || !cand) ? link_in.who : my_id;
        link_out.timed_out = link_in.timed_out;
        case (op.cmd)
            CMD_CANCEL_WR: link_out.timed_out = link_in.timed_out | (mine && wr_wait_reg);
            CMD_CANCEL_RD: link_out.timed_out = link_in.timed_out | (mine && rd_wait_reg);
            default:       link_out.timed_out = link_in.timed_out;
        endcase
    end

    // Set, release or cancel this task's wait bits
    always_comb
    begin
        rd_wait_next = rd_wait_reg;
        wr_wait_next = wr_wait_reg;
        if (op.accept)
        begin
            case (op.cmd)
                CMD_SEND:
                begin
                    if (failed)
                    begin
                        wr_wait_next = 1'b1;
                    end
                    if (claim)
                    begin
                        rd_wait_next = 1'b0;
                    end
                end
                CMD_READ:
                begin
                    if (failed)
                    begin
                        rd_wait_next = 1'b1;
                    end
                    if (claim)
                    begin
                        wr_wait_next = 1'b0;
                    end
                end
                CMD_CANCEL_WR:
                begin
                    if (mine)
                    begin
                        wr_wait_next = 1'b0;
                    end
                end
                CMD_CANCEL_RD:
                begin
                    if (mine)
                    begin
                        rd_wait_next = 1'b0;
                    end
                end
                default:
                begin
                    rd_wait_next = rd_wait_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_wait_reg <= 1'b0;
            wr_wait_reg <= 1'b0;
        end
        else
        begin
            rd_wait_reg <= rd_wait_next;
            wr_wait_reg <= wr_wait_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/message_queue_with_waiter_masks.sv =====
// Top level: mailbox ring of slot cells plus a chain of task wait cells.
// A command accepted at an edge reports its result on done in the next cycle.
// Throughput: one command per cycle; busy stays low, the slot and task chains
// settle within the cycle and the result register frees the next command.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the count and wait masks, puts the pointer tokens on slot zero and sets capacity to 16;
// message slots hold no defined value until written.
`default_nettype none
`include "message_queue_with_waiter_masks_assert.svh"

module message_queue_with_waiter_masks
    import mqwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        cmd,
    input  wire logic [MSG_W-1:0]  message,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic              wait_on_fail,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_data,
    output logic                   done,
    output logic                   success,
    output logic [MSG_W-1:0]       read_word,
    output logic                   wake_valid,
    output logic [TASK_W-1:0]      wake_task,
    output logic                   switch_request,
    output logic                   timed_out,
    output logic [FILL_W-1:0]      fill_level
);

    cmd_t              cmd_in;
    logic              accept;
    logic              send_ok;
    logic              read_ok;
    logic              ok;
    logic [CNT_W-1:0]  eff_cap_reg;
    logic [CNT_W-1:0]  held_count_reg;
    logic [CNT_W-1:0]  held_count_next;
    slot_ctl_t         slot_ctl;
    slot_link_t        slot_head;
    slot_link_t        slot_link [DEPTH];
    task_op_t          task_op;
    task_link_t        task_link [TASKS+1];
    logic              done_reg;
    logic              success_reg;
    logic [MSG_W-1:0]  read_word_reg;
    logic              wake_reg;
    logic [TASK_W-1:0] wake_task_reg;
    logic              timed_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cmd_in = cmd_t'(cmd);

    // Decide whether the send or read can go ahead
    assign send_ok = (cmd_in == CMD_SEND) && (held_count_reg < eff_cap_reg);
    assign read_ok = (cmd_in == CMD_READ) && (held_count_reg != '0);
    assign ok      = send_ok || read_ok;

    // Hold the clamped capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_cap_reg <= CNT_W'(EFF_CAP_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                eff_cap_reg <= CNT_W'(1);
            end
            else if (32'(cfg_data) > 32'(DEPTH))
            begin
                eff_cap_reg <= CNT_W'(DEPTH);
            end
            else
            begin
                eff_cap_reg <= CNT_W'(cfg_data);
            end
        end
    end

    // Track the number of held messages
    always_comb
    begin
        held_count_next = held_count_reg;
        if (accept && send_ok)
        begin
            held_count_next = held_count_reg + CNT_W'(1);
        end
        else if (accept && read_ok)
        begin
            held_count_next = held_count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
        end
        else
        begin
            held_count_reg <= held_count_next;
        end
    end

    // Drive the slot ring; slot zero takes the wrapped tokens
    always_comb
    begin
        slot_ctl.wr_adv    = accept && send_ok;
        slot_ctl.rd_adv    = accept && read_ok;
        slot_ctl.message   = message;
        slot_head.wr_tok   = slot_link[DEPTH-1].wr_wrap;
        slot_head.rd_tok   = slot_link[DEPTH-1].rd_wrap;
        slot_head.wr_wrap  = 1'b0;
        slot_head.rd_wrap  = 1'b0;
        slot_head.rdata    = '0;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        mqwm_slot_cell u_slot (
            .clk        (clk),
            .rst_n      (rst_n),
            .head       ((i == 0) ? 1'b1 : 1'b0),
            .cell_index (PTR_W'(i)),
            .eff_cap    (eff_cap_reg),
            .ctl        (slot_ctl),
            .link_in    ((i == 0) ? slot_head : slot_link[(i == 0) ? 0 : i-1]),
            .link_out   (slot_link[i])
        );
    end

    // Drive the task chain from the lowest task upward
    always_comb
    begin
        task_op.accept       = accept;
        task_op.cmd          = cmd_in;
        task_op.task_id      = task_id;
        task_op.wait_on_fail = wait_on_fail;
        task_op.release_wait = ok;
        task_link[0].found     = 1'b0;
        task_link[0].who       = '0;
        task_link[0].timed_out = 1'b0;
    end

    for (genvar t = 0; t < TASKS; t++)
    begin : g_task
        mqwm_task_cell u_task (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_id    (TASK_W'(t)),
            .op       (task_op),
            .link_in  (task_link[t]),
            .link_out (task_link[t+1])
        );
    end

    // Register the transaction result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            success_reg   <= ok;
            read_word_reg <= read_ok ? slot_link[DEPTH-1].rdata : '0;
            wake_reg      <= ok && task_link[TASKS].found;
            wake_task_reg <= (ok && task_link[TASKS].found) ? task_link[TASKS].who : '0;
            timed_out_reg <= task_link[TASKS].timed_out;
        end
    end

    assign done           = done_reg;
    assign success        = success_reg;
    assign read_word      = read_word_reg;
    assign wake_valid     = wake_reg;
    assign wake_task      = wake_task_reg;
    assign switch_request = wake_reg;
    assign timed_out      = timed_out_reg;
    assign fill_level     = FILL_W'(held_count_reg);

    // Every accepted command reports on the next cycle
    `MQWM_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done, "accepted command gave no result")
    // A released waiter only comes with a completed send or read
    `MQWM_ASSERT_NOW(a_wake_needs_success, clk, rst_n, done && wake_valid, success, "wake without success")
    // The held count never passes the buffer depth
    `MQWM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, held_count_reg <= CNT_W'(DEPTH), "count overflow")

endmodule

`default_nettype wire

// ===== dv/tb_message_queue_with_waiter_masks.sv =====
// Self-checking testbench for the mailbox with waiter masks: directed and random commands.
module tb_message_queue_with_waiter_masks;
    import mqwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_CMDS  = 105;

    typedef struct packed {
        cmd_t              op;
        logic [MSG_W-1:0]  msg;
        logic [TASK_W-1:0] tid;
        logic              wait_f;
        logic              drain;   // hold this command until nothing is outstanding
    } mbox_req_t;

    typedef struct packed {
        logic              success;
        logic [MSG_W-1:0]  word;
        logic              wake;
        logic [TASK_W-1:0] who;
        logic              sw;
        logic              tmo;
        logic [FILL_W-1:0] fill;
    } mbox_res_t;

    typedef struct packed {
        logic [DEPTH-1:0][MSG_W-1:0] slot;
        logic [DEPTH-1:0]            written;
        logic [PTR_W-1:0]            wptr;
        logic [PTR_W-1:0]            rptr;
        logic [CNT_W-1:0]            held;
        logic [TASKS-1:0]            rd_wait;
        logic [TASKS-1:0]            wr_wait;
        logic [CAP_W-1:0]            cap;
    } mbox_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        cmd = CMD_SEND;
    logic [MSG_W-1:0]  message = '0;
    logic [TASK_W-1:0] task_id = '0;
    logic              wait_on_fail = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CAP_W-1:0]  cfg_data = '0;
    logic              busy;
    logic              done;
    logic              success;
    logic [MSG_W-1:0]  read_word;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic              switch_request;
    logic              timed_out;
    logic [FILL_W-1:0] fill_level;

    mbox_req_t   cmd_backlog[$];
    mbox_res_t   due_replies[$];
    mbox_t       plan_box;
    mbox_t       track_box;
    mbox_req_t   on_port;
    int          idle_pct = 0;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          accepted = 0;
    int          wakes = 0;
    int          timeouts = 0;
    int          cap_settings = 0;

    message_queue_with_waiter_masks u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .message        (message),
        .task_id        (task_id),
        .wait_on_fail   (wait_on_fail),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .success        (success),
        .read_word      (read_word),
        .wake_valid     (wake_valid),
        .wake_task      (wake_task),
        .switch_request (switch_request),
        .timed_out      (timed_out),
        .fill_level     (fill_level)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Zero and one behave alike, anything above the depth is clamped
    function automatic int eff_cap(logic [CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    function automatic int lowest_waiter(logic [TASKS-1:0] m);
        for (int i = 0; i < TASKS; i++)
            if (m[i])
                return i;
        return -1;
    endfunction

    // Apply one mailbox command to a state copy and produce its reply
    task automatic mailbox_apply(inout mbox_t b, input mbox_req_t rq, output mbox_res_t rs);
        int               ecap;
        int               who;
        logic [TASKS-1:0] tbit;
        rs = '0;
        ecap = eff_cap(b.cap);
        tbit = '0;
        if (rq.tid < TASKS)
            tbit[rq.tid] = 1'b1;
        case (rq.op)
            CMD_SEND:
            begin
                if (b.held < ecap)
                begin
                    b.slot[b.wptr] = rq.msg;
                    b.written[b.wptr] = 1'b1;
                    b.wptr = (int'(b.wptr) + 1 >= ecap) ? '0 : b.wptr + 1'b1;
                    b.held = b.held + 1'b1;
                    rs.success = 1'b1;
                    who = lowest_waiter(b.rd_wait);
                    if (who >= 0)
                    begin
                        b.rd_wait[who] = 1'b0;
                        rs.wake = 1'b1;
                        rs.sw = 1'b1;
                        rs.who = who[TASK_W-1:0];
                    end
                end
                else if (rq.wait_f)
                    b.wr_wait = b.wr_wait | tbit;
            end
            CMD_READ:
            begin
                if (b.held != 0)
                begin
                    rs.word = b.slot[b.rptr];
                    b.rptr = (int'(b.rptr) + 1 >= ecap) ? '0 : b.rptr + 1'b1;
                    b.held = b.held - 1'b1;
                    rs.success = 1'b1;
                    who = lowest_waiter(b.wr_wait);
                    if (who >= 0)
                    begin
                        b.wr_wait[who] = 1'b0;
                        rs.wake = 1'b1;
                        rs.sw = 1'b1;
                        rs.who = who[TASK_W-1:0];
                    end
                end
                else if (rq.wait_f)
                    b.rd_wait = b.rd_wait | tbit;
            end
            CMD_CANCEL_WR:
            begin
                rs.tmo = |(b.wr_wait & tbit);
                b.wr_wait = b.wr_wait & ~tbit;
            end
            default:
            begin
                rs.tmo = |(b.rd_wait & tbit);
                b.rd_wait = b.rd_wait & ~tbit;
            end
        endcase
        rs.fill = FILL_W'(b.held);
    endtask

    task automatic report(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    endtask

    // Queue a command, tracking the planned state so no read hits a never-written slot
    task automatic queue_cmd(cmd_t op, logic [MSG_W-1:0] msg, logic [TASK_W-1:0] tid,
                             logic wf, logic hold);
        mbox_req_t rq;
        mbox_res_t unused;
        if (op == CMD_READ && plan_box.held != 0 && !plan_box.written[plan_box.rptr])
            op = CMD_SEND;
        rq = '{op: op, msg: msg, tid: tid, wait_f: wf, drain: hold};
        mailbox_apply(plan_box, rq, unused);
        cmd_backlog.push_back(rq);
    endtask

    function automatic logic [MSG_W-1:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TASK_W-1:0] random_task();
        if ($urandom_range(7) == 0)
            return TASK_W'(TASKS);
        return TASK_W'($urandom_range(TASKS - 1));
    endfunction

    // Bursts of sends, reads, cancels and mixed commands that walk the queue between empty and full
    task automatic random_phase(int n, int hold_at);
        int   made;
        int   kind;
        int   len;
        int   i;
        cmd_t op;
        logic wf;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(9);
            len = $urandom_range(1, eff_cap(plan_box.cap) + 3);
            for (i = 0; i < len && made < n; i++)
            begin
                wf = ($urandom_range(3) != 0);
                if (kind <= 3)
                    op = CMD_SEND;
                else if (kind <= 6)
                    op = CMD_READ;
                else if (kind == 7)
                    op = $urandom_range(1) ? CMD_CANCEL_WR : CMD_CANCEL_RD;
                else
                begin
                    op = cmd_t'($urandom_range(3));
                    wf = 1'($urandom_range(1));
                end
                queue_cmd(op, random_word(), random_task(), wf, made == hold_at);
                made++;
            end
        end
    endtask

    task automatic wait_settled();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || start || due_replies.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        plan_box.cap = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_settings++;
    endtask

    // Drive commands from the backlog; track the expected state at each accepted transaction
    always @(posedge clk)
    begin : drive_proc
        mbox_res_t due;
        if (rst_n)
        begin
            if (cfg_we)
                track_box.cap = cfg_data;
            if (start && !busy)
            begin
                mailbox_apply(track_box, on_port, due);
                due_replies.push_back(due);
                accepted++;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() != 0
                    && !(cmd_backlog[0].drain && due_replies.size() != 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    on_port = cmd_backlog.pop_front();
                    start <= 1'b1;
                    cmd <= on_port.op;
                    message <= on_port.msg;
                    task_id <= on_port.tid;
                    wait_on_fail <= on_port.wait_f;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Compare each reply transaction against the oldest expectation
    always @(posedge clk)
    begin : check_proc
        mbox_res_t want;
        if (rst_n && done)
        begin
            if (due_replies.size() == 0)
                report("reply with nothing outstanding", 1, 0);
            else
            begin
                want = due_replies.pop_front();
                if (success !== want.success)
                    report("success", success, want.success);
                if (read_word !== want.word)
                    report("read_word", read_word, want.word);
                if (wake_valid !== want.wake)
                    report("wake_valid", wake_valid, want.wake);
                if (wake_task !== want.who)
                    report("wake_task", wake_task, want.who);
                if (switch_request !== want.sw)
                    report("switch_request", switch_request, want.sw);
                if (timed_out !== want.tmo)
                    report("timed_out", timed_out, want.tmo);
                if (fill_level !== want.fill)
                    report("fill_level", fill_level, want.fill);
                if (want.wake)
                    wakes++;
                if (want.tmo)
                    timeouts++;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : run_proc
        int               p;
        logic [CAP_W-1:0] cap_v;
        plan_box = '0;
        plan_box.cap = CAP_W'(CAP_RESET);
        track_box = '0;
        track_box.cap = CAP_W'(CAP_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Readers wait on an empty queue, repeat waits, out-of-range task, cancels
        queue_cmd(CMD_READ, '0, 2'd0, 1'b1, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd2, 1'b1, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd3, 1'b1, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd1, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_RD, '0, 2'd2, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_RD, '0, 2'd2, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_RD, '0, 2'd3, 1'b0, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd0, 1'b1, 1'b0);
        queue_cmd(CMD_SEND, '0, 2'd1, 1'b0, 1'b0);
        queue_cmd(CMD_SEND, '1, 2'd2, 1'b1, 1'b0);
        queue_cmd(CMD_CANCEL_WR, '1, 2'd0, 1'b1, 1'b0);
        queue_cmd(CMD_READ, '1, 2'd1, 1'b1, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd2, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_RD, '0, 2'd0, 1'b0, 1'b0);
        wait_settled();

        // Single slot: writers wait on a full queue and a read releases the lowest
        set_capacity(5'd1);
        queue_cmd(CMD_SEND, 32'hA5A5_A5A5, 2'd0, 1'b0, 1'b0);
        queue_cmd(CMD_SEND, 32'h1111_1111, 2'd1, 1'b1, 1'b0);
        queue_cmd(CMD_SEND, 32'h2222_2222, 2'd2, 1'b1, 1'b0);
        queue_cmd(CMD_SEND, 32'h3333_3333, 2'd1, 1'b1, 1'b0);
        queue_cmd(CMD_SEND, 32'h4444_4444, 2'd3, 1'b1, 1'b0);
        queue_cmd(CMD_SEND, 32'h5555_5555, 2'd0, 1'b0, 1'b0);
        queue_cmd(CMD_READ, '0, 2'd0, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_WR, '0, 2'd1, 1'b0, 1'b0);
        queue_cmd(CMD_CANCEL_WR, '0, 2'd2, 1'b0, 1'b0);
        queue_cmd(CMD_SEND, 32'h5A5A_5A5A, 2'd2, 1'b0, 1'b1);
        queue_cmd(CMD_READ, '0, 2'd3, 1'b1, 1'b0);
        wait_settled();

        // Random phases over a spread of capacities, changed while messages are held
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 6)
                0: cap_v = 5'd0;
                1: cap_v = 5'd31;
                2: cap_v = 5'd16;
                3: cap_v = CAP_W'($urandom_range(31));
                4: cap_v = CAP_W'($urandom_range(2, 6));
                default: cap_v = 5'd1;
            endcase
            set_capacity(cap_v);
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 45 : 15);
            random_phase(PHASE_CMDS, (p == 4) ? PHASE_CMDS / 2 : -1);
            wait_settled();
        end

        repeat (4) @(posedge clk);
        $display("Covered %0d mailbox commands across %0d capacity writes in %0d cycles.",
                 accepted, cap_settings, cycle_count);
        $display("Replies included %0d task wakes and %0d cancelled waits still pending.",
                 wakes, timeouts);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
